FILE: src/kruskal_minimum_spanning_tree_assert.svh
// assertion macros for the kruskal spanning tree datapath
`ifndef KRUSKAL_MINIMUM_SPANNING_TREE_ASSERT_SVH
`define KRUSKAL_MINIMUM_SPANNING_TREE_ASSERT_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define KMST_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("kmst assertion failed");
// property whose consequent must hold in the cycle after the antecedent
`define KMST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kmst next-cycle assertion failed");
`else
`define KMST_ASSERT(lbl, prop)
`define KMST_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: src/kmst_pkg.sv
package kmst_pkg;

    // default sizes
    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_EDGES    = 256;
    localparam int DEF_WEIGHT_BITS  = 16;

    // vertex count after reset
    localparam int VCOUNT_RESET = 64;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic init_start;
        logic init_step;
        logic scan_start;
        logic scan_step;
        logic find_begin;
        logic find_chk;
        logic comp_chk;
        logic rank_a_sel;
        logic rank_b_cap;
        logic unite;
        logic skip;
        logic sum;
    } kmst_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic init_last;
        logic scan_done;
        logic have_best;
        logic count_full;
        logic hi_bad;
        logic root_hit;
        logic comp_done;
        logic side;
        logic roots_eq;
        logic out_xfer;
    } kmst_sts_t;

endpackage

FILE: src/kmst_ctrl.sv
module kmst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              last_edge,
    output logic              in_ready,
    input  kmst_pkg::kmst_sts_t sts,
    output kmst_pkg::kmst_cmd_t cmd
);
    import kmst_pkg::*;

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_INIT       = 4'd1;
    localparam logic [3:0] S_SCAN_START = 4'd2;
    localparam logic [3:0] S_SCAN       = 4'd3;
    localparam logic [3:0] S_FIND_RD    = 4'd4;
    localparam logic [3:0] S_FIND_CHK   = 4'd5;
    localparam logic [3:0] S_COMP_RD    = 4'd6;
    localparam logic [3:0] S_COMP_CHK   = 4'd7;
    localparam logic [3:0] S_JOIN_CHK   = 4'd8;
    localparam logic [3:0] S_RANK_A     = 4'd9;
    localparam logic [3:0] S_RANK_B     = 4'd10;
    localparam logic [3:0] S_JOIN       = 4'd11;
    localparam logic [3:0] S_OUT        = 4'd12;
    localparam logic [3:0] S_SUM        = 4'd13;
    localparam logic [3:0] S_SUM_OUT    = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (last_edge)
                    begin
                        cmd.init_start = 1'b1;
                        state_next     = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                cmd.init_step = 1'b1;
                if (sts.init_last)
                begin
                    state_next = S_SCAN_START;
                end
            end
            S_SCAN_START:
            begin
                if (sts.count_full)
                begin
                    state_next = S_SUM;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    if (!sts.have_best)
                    begin
                        state_next = S_SUM;
                    end
                    else if (sts.hi_bad)
                    begin
                        cmd.skip   = 1'b1;
                        state_next = S_SCAN_START;
                    end
                    else
                    begin
                        cmd.find_begin = 1'b1;
                        state_next     = S_FIND_RD;
                    end
                end
            end
            S_FIND_RD:
            begin
                state_next = S_FIND_CHK;
            end
            S_FIND_CHK:
            begin
                cmd.find_chk = 1'b1;
                state_next   = sts.root_hit ? S_COMP_RD : S_FIND_RD;
            end
            S_COMP_RD:
            begin
                state_next = S_COMP_CHK;
            end
            S_COMP_CHK:
            begin
                cmd.comp_chk = 1'b1;
                if (sts.comp_done)
                begin
                    state_next = sts.side ? S_JOIN_CHK : S_FIND_RD;
                end
                else
                begin
                    state_next = S_COMP_RD;
                end
            end
            S_JOIN_CHK:
            begin
                if (sts.roots_eq)
                begin
                    cmd.skip   = 1'b1;
                    state_next = S_SCAN_START;
                end
                else
                begin
                    state_next = S_RANK_A;
                end
            end
            S_RANK_A:
            begin
                cmd.rank_a_sel = 1'b1;
                state_next     = S_RANK_B;
            end
            S_RANK_B:
            begin
                cmd.rank_b_cap = 1'b1;
                state_next     = S_JOIN;
            end
            S_JOIN:
            begin
                cmd.unite  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_xfer)
                begin
                    state_next = S_SCAN_START;
                end
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_SUM_OUT;
            end
            S_SUM_OUT:
            begin
                if (sts.out_xfer)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/kmst_datapath.sv
`include "kruskal_minimum_spanning_tree_assert.svh"

module kmst_datapath #(
    parameter int MAX_VERTICES = kmst_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = kmst_pkg::DEF_MAX_EDGES,
    parameter int WEIGHT_BITS  = kmst_pkg::DEF_WEIGHT_BITS,
    parameter int VTX_W        = $clog2(MAX_VERTICES),
    parameter int CFG_W        = VTX_W + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kmst_pkg::kmst_cmd_t           cmd,
    output kmst_pkg::kmst_sts_t           sts,
    input  logic [CFG_W-1:0]              nv_eff,
    input  logic [VTX_W-1:0]              edge_src,
    input  logic [VTX_W-1:0]              edge_dst,
    input  logic signed [WEIGHT_BITS-1:0] edge_weight,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [VTX_W-1:0]              tree_src,
    output logic [VTX_W-1:0]              tree_dst,
    output logic signed [WEIGHT_BITS-1:0] tree_weight,
    output logic                          is_summary,
    output logic signed [WEIGHT_BITS+VTX_W-1:0] total_weight,
    output logic [VTX_W-1:0]              tree_edge_count,
    output logic                          dropped_flag,
    output logic                          last_result
);
    import kmst_pkg::*;

    localparam int EIDX_W = $clog2(MAX_EDGES);
    localparam int ECNT_W = EIDX_W + 1;
    localparam int ENT_W  = 2 * VTX_W + WEIGHT_BITS;
    localparam int RANK_W = $clog2(VTX_W + 1);
    localparam int TOT_W  = WEIGHT_BITS + VTX_W;

    // edge store and load bookkeeping
    logic [ENT_W-1:0]  edge_mem [MAX_EDGES];
    logic [ENT_W-1:0]  edge_rd_reg;
    logic [ECNT_W-1:0] stored_reg;
    logic              drop_reg;

    // selection scan
    logic [ECNT_W-1:0]             scan_idx_reg;
    logic [EIDX_W-1:0]             rd_idx_reg;
    logic                          rd_vld_reg;
    logic                          have_best_reg;
    logic [EIDX_W-1:0]             best_idx_reg;
    logic [VTX_W-1:0]              best_lo_reg;
    logic [VTX_W-1:0]              best_hi_reg;
    logic signed [WEIGHT_BITS-1:0] best_w_reg;
    logic                          have_prev_reg;
    logic [EIDX_W-1:0]             prev_idx_reg;
    logic signed [WEIGHT_BITS-1:0] prev_w_reg;

    // union-find store
    logic [VTX_W-1:0]  par_mem [MAX_VERTICES];
    logic [RANK_W-1:0] rank_mem [MAX_VERTICES];
    logic [VTX_W-1:0]  par_rd_reg;
    logic [RANK_W-1:0] rank_rd_reg;
    logic [VTX_W-1:0]  cur_reg;
    logic [VTX_W-1:0]  root_reg;
    logic [VTX_W-1:0]  root_a_reg;
    logic [RANK_W-1:0] rank_a_reg;
    logic              side_reg;

    // tree totals
    logic [VTX_W-1:0]        count_reg;
    logic signed [TOT_W-1:0] total_reg;

    // output register
    logic                          out_valid_reg;
    logic [VTX_W-1:0]              tree_src_reg;
    logic [VTX_W-1:0]              tree_dst_reg;
    logic signed [WEIGHT_BITS-1:0] tree_weight_reg;
    logic                          is_summary_reg;
    logic signed [TOT_W-1:0]       total_weight_reg;
    logic [VTX_W-1:0]              tree_edge_count_reg;
    logic                          dropped_flag_reg;
    logic                          last_result_reg;

    // load decode
    logic             ld_bad;
    logic             ld_self;
    logic             ld_full;
    logic             ld_write;
    logic [VTX_W-1:0] ld_lo;
    logic [VTX_W-1:0] ld_hi;

    assign ld_bad   = ({1'b0, edge_src} >= nv_eff) || ({1'b0, edge_dst} >= nv_eff);
    assign ld_self  = (edge_src == edge_dst);
    assign ld_full  = (stored_reg == ECNT_W'(MAX_EDGES));
    assign ld_write = cmd.load && !ld_bad && !ld_self && !ld_full;
    assign ld_lo    = (edge_src < edge_dst) ? edge_src : edge_dst;
    assign ld_hi    = (edge_src < edge_dst) ? edge_dst : edge_src;

    // scan compare against previous pick and current best
    logic signed [WEIGHT_BITS-1:0] rd_w;
    logic                          rd_after_prev;
    logic                          rd_better;
    logic                          rd_take;

    assign rd_w          = $signed(edge_rd_reg[WEIGHT_BITS-1:0]);
    assign rd_after_prev = !have_prev_reg || (rd_w > prev_w_reg)
                           || ((rd_w == prev_w_reg) && (rd_idx_reg > prev_idx_reg));
    assign rd_better     = !have_best_reg || (rd_w < best_w_reg);
    assign rd_take       = cmd.scan_step && rd_vld_reg && rd_after_prev && rd_better;

    // union-find write ports
    logic              par_we;
    logic [VTX_W-1:0]  par_waddr;
    logic [VTX_W-1:0]  par_wdata;
    logic              rank_we;
    logic [VTX_W-1:0]  rank_waddr;
    logic [RANK_W-1:0] rank_wdata;
    logic [VTX_W-1:0]  rank_raddr;
    logic              a_below_b;

    assign a_below_b  = (rank_a_reg < rank_rd_reg);
    assign rank_raddr = cmd.rank_a_sel ? root_a_reg : root_reg;

    always_comb
    begin
        par_we     = 1'b0;
        par_waddr  = cur_reg;
        par_wdata  = cur_reg;
        rank_we    = 1'b0;
        rank_waddr = cur_reg;
        rank_wdata = '0;
        if (cmd.init_step)
        begin
            par_we  = 1'b1;
            rank_we = 1'b1;
        end
        else if (cmd.comp_chk && (par_rd_reg != root_reg))
        begin
            par_we    = 1'b1;
            par_wdata = root_reg;
        end
        else if (cmd.unite)
        begin
            par_we = 1'b1;
            if (a_below_b)
            begin
                par_waddr = root_a_reg;
                par_wdata = root_reg;
            end
            else
            begin
                par_waddr = root_reg;
                par_wdata = root_a_reg;
            end
            if (rank_a_reg == rank_rd_reg)
            begin
                rank_we    = 1'b1;
                rank_waddr = root_a_reg;
                rank_wdata = rank_a_reg + RANK_W'(1);
            end
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (ld_write)
        begin
            edge_mem[stored_reg[EIDX_W-1:0]] <= {ld_lo, ld_hi, edge_weight};
        end
        edge_rd_reg <= edge_mem[scan_idx_reg[EIDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            par_mem[par_waddr] <= par_wdata;
        end
        par_rd_reg <= par_mem[cur_reg];
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_mem[rank_waddr] <= rank_wdata;
        end
        rank_rd_reg <= rank_mem[rank_raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg    <= '0;
            drop_reg      <= 1'b0;
            scan_idx_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            have_best_reg <= 1'b0;
            have_prev_reg <= 1'b0;
            side_reg      <= 1'b0;
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // edge loading
            if (cmd.load && (ld_bad || (!ld_self && ld_full)))
            begin
                drop_reg <= 1'b1;
            end
            if (ld_write)
            begin
                stored_reg <= stored_reg + ECNT_W'(1);
            end
            // start of a run
            if (cmd.init_start)
            begin
                count_reg     <= '0;
                total_reg     <= '0;
                have_prev_reg <= 1'b0;
            end
            // selection scan
            if (cmd.scan_start)
            begin
                scan_idx_reg  <= '0;
                rd_vld_reg    <= 1'b0;
                have_best_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                rd_vld_reg <= (scan_idx_reg != stored_reg);
                if (scan_idx_reg != stored_reg)
                begin
                    scan_idx_reg <= scan_idx_reg + ECNT_W'(1);
                end
                if (rd_take)
                begin
                    have_best_reg <= 1'b1;
                end
            end
            if (cmd.find_begin)
            begin
                side_reg <= 1'b0;
            end
            if (cmd.comp_chk && (par_rd_reg == root_reg))
            begin
                side_reg <= 1'b1;
            end
            if (cmd.skip || cmd.unite)
            begin
                have_prev_reg <= 1'b1;
            end
            if (cmd.unite)
            begin
                count_reg <= count_reg + VTX_W'(1);
                total_reg <= total_reg + TOT_W'(best_w_reg);
            end
            // summary ends the graph
            if (cmd.sum)
            begin
                stored_reg <= '0;
                drop_reg   <= 1'b0;
            end
            // output handshake
            if (cmd.unite || cmd.sum)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_idx_reg[EIDX_W-1:0];
        if (rd_take)
        begin
            best_idx_reg <= rd_idx_reg;
            best_lo_reg  <= edge_rd_reg[ENT_W-1 -: VTX_W];
            best_hi_reg  <= edge_rd_reg[WEIGHT_BITS+VTX_W-1 -: VTX_W];
            best_w_reg   <= rd_w;
        end
        if (cmd.skip || cmd.unite)
        begin
            prev_idx_reg <= best_idx_reg;
            prev_w_reg   <= best_w_reg;
        end
        // walk of the union-find chains
        if (cmd.init_start)
        begin
            cur_reg <= '0;
        end
        else if (cmd.init_step)
        begin
            cur_reg <= cur_reg + VTX_W'(1);
        end
        else if (cmd.find_begin)
        begin
            cur_reg <= best_lo_reg;
        end
        else if (cmd.find_chk)
        begin
            if (par_rd_reg == cur_reg)
            begin
                root_reg <= cur_reg;
                cur_reg  <= side_reg ? best_hi_reg : best_lo_reg;
            end
            else
            begin
                cur_reg <= par_rd_reg;
            end
        end
        else if (cmd.comp_chk)
        begin
            if (par_rd_reg == root_reg)
            begin
                if (!side_reg)
                begin
                    root_a_reg <= root_reg;
                    cur_reg    <= best_hi_reg;
                end
            end
            else
            begin
                cur_reg <= par_rd_reg;
            end
        end
        if (cmd.rank_b_cap)
        begin
            rank_a_reg <= rank_rd_reg;
        end
        // result items
        if (cmd.unite)
        begin
            tree_src_reg        <= best_lo_reg;
            tree_dst_reg        <= best_hi_reg;
            tree_weight_reg     <= best_w_reg;
            is_summary_reg      <= 1'b0;
            total_weight_reg    <= '0;
            tree_edge_count_reg <= '0;
            dropped_flag_reg    <= drop_reg;
            last_result_reg     <= 1'b0;
        end
        else if (cmd.sum)
        begin
            tree_src_reg        <= '0;
            tree_dst_reg        <= '0;
            tree_weight_reg     <= '0;
            is_summary_reg      <= 1'b1;
            total_weight_reg    <= total_reg;
            tree_edge_count_reg <= count_reg;
            dropped_flag_reg    <= drop_reg;
            last_result_reg     <= 1'b1;
        end
    end

    // status to controller
    always_comb
    begin
        sts            = '0;
        sts.init_last  = (cur_reg == VTX_W'(MAX_VERTICES - 1));
        sts.scan_done  = (scan_idx_reg == stored_reg) && !rd_vld_reg;
        sts.have_best  = have_best_reg;
        sts.count_full = (count_reg == VTX_W'(MAX_VERTICES - 1));
        sts.hi_bad     = ({1'b0, best_hi_reg} >= nv_eff);
        sts.root_hit   = (par_rd_reg == cur_reg);
        sts.comp_done  = (par_rd_reg == root_reg);
        sts.side       = side_reg;
        sts.roots_eq   = (root_a_reg == root_reg);
        sts.out_xfer   = out_valid_reg && out_ready;
    end

    assign out_valid       = out_valid_reg;
    assign tree_src        = tree_src_reg;
    assign tree_dst        = tree_dst_reg;
    assign tree_weight     = tree_weight_reg;
    assign is_summary      = is_summary_reg;
    assign total_weight    = total_weight_reg;
    assign tree_edge_count = tree_edge_count_reg;
    assign dropped_flag    = dropped_flag_reg;
    assign last_result     = last_result_reg;

    // checks
    `KMST_ASSERT(a_store_bound, stored_reg <= ECNT_W'(MAX_EDGES))
    `KMST_ASSERT(a_read_pending, rd_vld_reg |-> (scan_idx_reg != '0))
    `KMST_ASSERT_NEXT(a_sum_clears, cmd.sum, (stored_reg == '0) && out_valid_reg && last_result_reg)
    `KMST_ASSERT_NEXT(a_join_counts, cmd.unite, (count_reg == $past(count_reg) + VTX_W'(1)) && !last_result_reg)

endmodule

FILE: src/kruskal_minimum_spanning_tree.sv
// Minimum spanning forest engine. Edges are taken one per cycle while the block is idle;
// all but self-loops, out-of-range edges and edges past capacity are written into an edge
// memory. An edge with last_edge set starts the run, and in_ready stays low until the
// summary item has been transferred. A run first resets the union-find store, one vertex
// per cycle, then repeats a selection scan over the edge memory that picks the next edge
// in weight order, ties in load order; each pick walks both endpoint chains and compresses
// them, compares the two roots, and an accepted edge reads both root ranks, unites the
// roots and waits for the output transfer. Accepted edges come out smaller vertex first,
// followed by one summary item carrying the total weight and edge count.
module kruskal_minimum_spanning_tree #(
    parameter int MAX_VERTICES = kmst_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = kmst_pkg::DEF_MAX_EDGES,
    parameter int WEIGHT_BITS  = kmst_pkg::DEF_WEIGHT_BITS,
    parameter int VTX_W        = $clog2(MAX_VERTICES),
    parameter int CFG_W        = VTX_W + 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [VTX_W-1:0]              edge_src,
    input  logic [VTX_W-1:0]              edge_dst,
    input  logic signed [WEIGHT_BITS-1:0] edge_weight,
    input  logic                          last_edge,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [VTX_W-1:0]              tree_src,
    output logic [VTX_W-1:0]              tree_dst,
    output logic signed [WEIGHT_BITS-1:0] tree_weight,
    output logic                          is_summary,
    output logic signed [WEIGHT_BITS+VTX_W-1:0] total_weight,
    output logic [VTX_W-1:0]              tree_edge_count,
    output logic                          dropped_flag,
    output logic                          last_result
);
    import kmst_pkg::*;

    localparam int RESET_VC = (VCOUNT_RESET > MAX_VERTICES) ? MAX_VERTICES : VCOUNT_RESET;

    logic [CFG_W-1:0] vcount_reg;
    logic [CFG_W-1:0] nv_eff;
    kmst_cmd_t        cmd;
    kmst_sts_t        sts;

    // vertex count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= CFG_W'(RESET_VC);
        end
        else if (cfg_valid)
        begin
            vcount_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    // counts above capacity act as full capacity
    assign nv_eff = (vcount_reg > CFG_W'(MAX_VERTICES)) ? CFG_W'(MAX_VERTICES) : vcount_reg;

    kmst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_edge (last_edge),
        .in_ready  (in_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    kmst_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .WEIGHT_BITS  (WEIGHT_BITS),
        .VTX_W        (VTX_W),
        .CFG_W        (CFG_W)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .nv_eff          (nv_eff),
        .edge_src        (edge_src),
        .edge_dst        (edge_dst),
        .edge_weight     (edge_weight),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .tree_src        (tree_src),
        .tree_dst        (tree_dst),
        .tree_weight     (tree_weight),
        .is_summary      (is_summary),
        .total_weight    (total_weight),
        .tree_edge_count (tree_edge_count),
        .dropped_flag    (dropped_flag),
        .last_result     (last_result)
    );

endmodule
